// ===== hdl/smpt_pkg.sv =====
// package: shared types and constants of the sparse matrix purge table
`timescale 1ns / 1ps
`default_nettype none
package smpt_pkg;

  localparam int PAIR_W = 11;
  localparam int MINC_W = 13;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_DEL = 2'd1;
  localparam logic [1:0] ACT_SUM2 = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_LIVE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_LIVE = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  row;
    logic [11:0] column;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        col_weight;
    logic [PAIR_W-1:0] pair_row_sum;
    logic [10:0]       live_rows;
    logic [12:0]       live_cols;
  } result_t;

  typedef enum logic [1:0] {
    RES_ADD,
    RES_QRY,
    RES_BAD_DEL,
    RES_OK
  } res_kind_t;

  typedef struct packed {
    logic      rd_in;
    logic      clr_init;
    logic      clr_pair;
    logic      clr_rst;
    logic      clr_step;
    logic      add_wr;
    logic      del_start;
    logic      rd_entry;
    logic      scan_sel;
    logic      rd_col;
    logic      del_upd;
    logic      del_fin;
    logic      sum_rowrd;
    logic      sum_start;
    logic      sum_upd;
    logic      sum_next;
    logic      scan_rst;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic clr_init_last;
    logic clr_pair_last;
    logic del_ok;
    logic ri_live;
    logic k_done;
    logic r_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/smpt_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module smpt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smpt_ctrl.sv =====
// controller: sequencing of add, delete, pair sum and query
`timescale 1ns / 1ps
`default_nettype none
module smpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire logic [1:0]    action,
  output logic               result_valid,
  input  wire logic          result_ready,
  output smpt_pkg::cmd_t     cmd,
  input  wire smpt_pkg::sts_t sts
);
  import smpt_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ADD, S_QRY, S_DEL_CHK, S_DEL_RD, S_DEL_E, S_DEL_W,
    S_CLR, S_SC_RI, S_SC_CHK, S_SC_RD, S_SC_E, S_SC_W, S_FIN
  } state_t;

  state_t state, state_next;
  logic slot_free;
  logic accept;

  assign item_ready = (state == S_IDLE);
  assign accept = item_valid && item_ready;
  assign slot_free = !result_valid || result_ready;

  always_comb begin
    cmd = '0;
    cmd.res_kind = RES_OK;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.clr_init = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.rd_in = 1'b1;
          cmd.clr_rst = 1'b1;
          case (action)
            ACT_ADD: state_next = S_ADD;
            ACT_DEL: state_next = S_DEL_CHK;
            ACT_SUM2: state_next = S_CLR;
            default: state_next = S_QRY;
          endcase
        end
      end
      S_ADD: begin
        if (slot_free) begin
          cmd.add_wr = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_ADD;
          state_next = S_IDLE;
        end
      end
      S_QRY: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_QRY;
          state_next = S_IDLE;
        end
      end
      S_DEL_CHK: begin
        if (!sts.del_ok) begin
          if (slot_free) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_BAD_DEL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.del_start = 1'b1;
          state_next = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        if (sts.k_done) begin
          if (slot_free) begin
            cmd.del_fin = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_OK;
            state_next = S_IDLE;
          end
        end else begin
          cmd.rd_entry = 1'b1;
          state_next = S_DEL_E;
        end
      end
      S_DEL_E: begin
        cmd.rd_col = 1'b1;
        state_next = S_DEL_W;
      end
      S_DEL_W: begin
        cmd.del_upd = 1'b1;
        state_next = S_DEL_RD;
      end
      S_CLR: begin
        cmd.clr_pair = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_pair_last) begin
          cmd.scan_rst = 1'b1;
          state_next = S_SC_RI;
        end
      end
      S_SC_RI: begin
        cmd.sum_rowrd = 1'b1;
        state_next = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (sts.ri_live) begin
          cmd.sum_start = 1'b1;
          state_next = S_SC_RD;
        end else if (sts.r_last) begin
          state_next = S_FIN;
        end else begin
          cmd.sum_next = 1'b1;
          state_next = S_SC_RI;
        end
      end
      S_SC_RD: begin
        cmd.scan_sel = 1'b1;
        if (sts.k_done) begin
          if (sts.r_last) begin
            state_next = S_FIN;
          end else begin
            cmd.sum_next = 1'b1;
            state_next = S_SC_RI;
          end
        end else begin
          cmd.rd_entry = 1'b1;
          state_next = S_SC_E;
        end
      end
      S_SC_E: begin
        cmd.scan_sel = 1'b1;
        cmd.rd_col = 1'b1;
        state_next = S_SC_W;
      end
      S_SC_W: begin
        cmd.scan_sel = 1'b1;
        cmd.sum_upd = 1'b1;
        state_next = S_SC_RD;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_OK;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smpt_dp.sv =====
// datapath: table memories, counters and result register
`timescale 1ns / 1ps
`default_nettype none
module smpt_dp #(
  parameter int ROWS = 1024,
  parameter int COLS = 4096,
  parameter int MAX_ROW_LEN = 32,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire smpt_pkg::item_t               item_in,
  input  wire logic                          cfg_we,
  input  wire logic [smpt_pkg::MINC_W-1:0]   cfg_wdata,
  input  wire smpt_pkg::cmd_t                cmd,
  output smpt_pkg::sts_t                     sts,
  output smpt_pkg::result_t                  result
);
  import smpt_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LW = $clog2(MAX_ROW_LEN + 1);
  localparam int IW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int EAW = RW + IW;
  localparam int MAXD = (COLS > ROWS) ? COLS : ROWS;
  localparam int NW = $clog2(MAXD);
  localparam int LRW = $clog2(ROWS + 1);
  localparam int LCW = $clog2(COLS + 1);
  localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
  localparam logic [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1);
  localparam logic [WEIGHT_BITS-1:0] W_TWO = WEIGHT_BITS'(2);

  item_t              item;
  logic [LW-1:0]      k;
  logic [LW-1:0]      len_lat;
  logic [RW-1:0]      scan_r;
  logic [NW-1:0]      clr_cnt;
  logic [LRW-1:0]     live_rows;
  logic [LCW-1:0]     live_cols;
  logic [LRW-1:0]     live_rows_next;
  logic [LCW-1:0]     live_cols_next;
  logic [MINC_W-1:0]  min_col;

  logic                   w_we, w_re;
  logic [CW-1:0]          w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rd;
  logic                   p_we, p_re;
  logic [CW-1:0]          p_waddr, p_raddr;
  logic [PAIR_W-1:0]      p_wdata, p_rd;
  logic                   ri_we, ri_re;
  logic [RW-1:0]          ri_waddr, ri_raddr;
  logic [LW:0]            ri_wdata, ri_rd;
  logic                   e_we, e_re;
  logic [EAW-1:0]         e_waddr, e_raddr;
  logic [CW-1:0]          ent_rd;

  logic [RW-1:0]          item_row;
  logic                   ri_live;
  logic [LW-1:0]          ri_len;
  logic                   a_row_ok, a_col_ok, a_store, a_full, a_open, a_wupd;
  logic [WEIGHT_BITS-1:0] w_inc;
  logic [LW-1:0]          len_new;
  logic [1:0]             a_status;
  logic                   d_dec;
  logic                   q_col_ok;
  logic                   clr_cols, clr_rows;

  smpt_ram #(.W(WEIGHT_BITS), .D(COLS)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rd)
  );
  smpt_ram #(.W(PAIR_W), .D(COLS)) u_pair (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rd)
  );
  smpt_ram #(.W(LW + 1), .D(ROWS)) u_rowinfo (
    .clk(clk), .we(ri_we), .waddr(ri_waddr), .wdata(ri_wdata),
    .re(ri_re), .raddr(ri_raddr), .rdata(ri_rd)
  );
  smpt_ram #(.W(CW), .D(ROWS * (2 ** IW))) u_entry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(item.column[CW-1:0]),
    .re(e_re), .raddr(e_raddr), .rdata(ent_rd)
  );

  assign item_row = RW'(item.row);
  assign ri_live = ri_rd[LW];
  assign ri_len = ri_rd[LW-1:0];
  assign clr_cols = 32'(clr_cnt) < 32'(COLS);
  assign clr_rows = 32'(clr_cnt) < 32'(ROWS);

  always_comb begin
    a_row_ok = 32'(item.row) < 32'(ROWS);
    a_col_ok = 32'(item.column) < 32'(COLS);
    q_col_ok = a_col_ok;
    a_store = a_col_ok && ({1'b0, item.column} >= min_col);
    a_full = ri_len >= LW'(MAX_ROW_LEN);
    a_open = a_row_ok && !ri_live;
    a_wupd = a_open && a_col_ok && !(a_store && a_full);
    if (w_rd == '0) begin
      w_inc = W_ONE;
    end else if (w_rd != WMAX) begin
      w_inc = w_rd + W_ONE;
    end else begin
      w_inc = w_rd;
    end
    len_new = ri_len + LW'(a_wupd && a_store);
    if (!a_row_ok) begin
      a_status = ST_FULL;
    end else if (ri_live) begin
      a_status = ST_LIVE;
    end else if (a_store && a_full) begin
      a_status = ST_FULL;
    end else begin
      a_status = ST_OK;
    end
    d_dec = (w_rd != '0) && (w_rd != WMAX);
  end

  always_comb begin
    w_re = cmd.rd_in || cmd.rd_col;
    w_raddr = cmd.rd_in ? CW'(item_in.column) : ent_rd;
    p_re = w_re;
    p_raddr = w_raddr;
    ri_re = cmd.rd_in || cmd.sum_rowrd;
    ri_raddr = cmd.rd_in ? RW'(item_in.row) : scan_r;
    e_re = cmd.rd_entry;
    e_raddr = {(cmd.scan_sel ? scan_r : item_row), k[IW-1:0]};

    w_we = 1'b0;
    w_waddr = ent_rd;
    w_wdata = w_rd - W_ONE;
    if (cmd.clr_init) begin
      w_we = clr_cols;
      w_waddr = CW'(clr_cnt);
      w_wdata = '0;
    end else if (cmd.add_wr) begin
      w_we = a_wupd;
      w_waddr = item.column[CW-1:0];
      w_wdata = w_inc;
    end else if (cmd.del_upd) begin
      w_we = d_dec;
    end

    p_we = 1'b0;
    p_waddr = ent_rd;
    p_wdata = p_rd + PAIR_W'(scan_r);
    if (cmd.clr_init || cmd.clr_pair) begin
      p_we = clr_cols;
      p_waddr = CW'(clr_cnt);
      p_wdata = '0;
    end else if (cmd.sum_upd) begin
      p_we = (w_rd == W_TWO);
    end

    ri_we = 1'b0;
    ri_waddr = item_row;
    ri_wdata = '0;
    if (cmd.clr_init) begin
      ri_we = clr_rows;
      ri_waddr = RW'(clr_cnt);
    end else if (cmd.add_wr) begin
      ri_we = a_open;
      ri_wdata = {item.last, len_new};
    end else if (cmd.del_fin) begin
      ri_we = 1'b1;
    end

    e_we = cmd.add_wr && a_wupd && a_store;
    e_waddr = {item_row, ri_len[IW-1:0]};
  end

  always_comb begin
    live_rows_next = live_rows;
    live_cols_next = live_cols;
    if (cmd.add_wr && a_open && item.last) live_rows_next = live_rows + LRW'(1);
    if (cmd.del_fin) live_rows_next = live_rows - LRW'(1);
    if (cmd.add_wr && a_wupd && (w_rd == '0)) live_cols_next = live_cols + LCW'(1);
    if (cmd.del_upd && d_dec && (w_rd == W_ONE)) live_cols_next = live_cols - LCW'(1);
  end

  always_comb begin
    sts.clr_init_last = 32'(clr_cnt) == 32'(MAXD - 1);
    sts.clr_pair_last = 32'(clr_cnt) == 32'(COLS - 1);
    sts.del_ok = a_row_ok && ri_live;
    sts.ri_live = ri_live;
    sts.k_done = k >= len_lat;
    sts.r_last = 32'(scan_r) == 32'(ROWS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      live_rows <= '0;
      live_cols <= '0;
      min_col <= '0;
    end else begin
      if (cmd.clr_rst) begin
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + NW'(1);
      end
      live_rows <= live_rows_next;
      live_cols <= live_cols_next;
      if (cfg_we) min_col <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_in) item <= item_in;
    if (cmd.del_start || cmd.sum_start) begin
      k <= '0;
      len_lat <= ri_len;
    end else if (cmd.del_upd || cmd.sum_upd) begin
      k <= k + LW'(1);
    end
    if (cmd.scan_rst) begin
      scan_r <= '0;
    end else if (cmd.sum_next) begin
      scan_r <= scan_r + RW'(1);
    end
    if (cmd.res_load) begin
      result.live_rows <= 11'(live_rows_next);
      result.live_cols <= 13'(live_cols_next);
      result.status <= ST_OK;
      result.col_weight <= '0;
      result.pair_row_sum <= '0;
      case (cmd.res_kind)
        RES_ADD: begin
          result.status <= a_status;
          result.col_weight <= a_wupd ? 8'(w_inc) : 8'd0;
        end
        RES_QRY: begin
          if (q_col_ok) begin
            result.col_weight <= 8'(w_rd);
            result.pair_row_sum <= p_rd;
          end
        end
        RES_BAD_DEL: result.status <= ST_NOT_LIVE;
        default: result.status <= ST_OK;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sparse_matrix_purge_table_unit.sv =====
// top level: sparse matrix purge table
// add and query: the beat is taken in idle, the result is loaded in the add or query state once the result slot is free
// delete: a live check, then one ram read chain per stored column of the row (entry, weight, write back)
// sum2: clear the pair sums of all COLS columns, then read each row's info and, for each live row,
// walk its stored columns, adding the row index to the pair sum of each column of weight two, then load the result
// one item in flight at a time; a waiting result does not block the next beat
// after reset a clearing pass over max(COLS, ROWS) addresses runs with item_ready low
`timescale 1ns / 1ps
`default_nettype none
module sparse_matrix_purge_table_unit #(
  parameter int ROWS = 1024,
  parameter int COLS = 4096,
  parameter int MAX_ROW_LEN = 32,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire smpt_pkg::item_t             item,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output smpt_pkg::result_t                result,
  input  wire logic                        cfg_we,
  input  wire logic [smpt_pkg::MINC_W-1:0] cfg_wdata
);
  import smpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smpt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .action(item.action),
    .result_valid(result_valid), .result_ready(result_ready),
    .cmd(cmd), .sts(sts)
  );

  smpt_dp #(
    .ROWS(ROWS), .COLS(COLS), .MAX_ROW_LEN(MAX_ROW_LEN), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .item_in(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .sts(sts), .result(result)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second beat taken while an item is in flight");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |->
      (result.col_weight == 8'd0 && result.pair_row_sum == '0))
    else $error("error result carries data");

  a_reset_clear: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !item_ready)
    else $error("beat taken before clearing pass");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the sparse matrix purge table: directed and random items against a predictor
`timescale 1ns / 1ps
module tb;
  import smpt_pkg::*;

  localparam int NROWS = 1024;
  localparam int NCOLS = 4096;
  localparam int ROW_CAP = 32;
  localparam logic [7:0] WSAT = 8'hFF;
  localparam int STALL_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [MINC_W-1:0] cfg_wdata = '0;

  // purge table state kept by the testbench
  logic [7:0] col_wt [NCOLS];
  logic [PAIR_W-1:0] col_pair [NCOLS];
  logic [11:0] row_cols [NROWS][ROW_CAP];
  int unsigned row_len [NROWS];
  bit row_is_live [NROWS];
  logic [10:0] n_live_rows;
  logic [12:0] n_live_cols;
  logic [MINC_W-1:0] min_col;

  result_t pending_results [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  sparse_matrix_purge_table_unit i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  function automatic result_t purge_table_step(item_t it);
    result_t r;
    logic [11:0] c;
    bit store;
    r = '0;
    case (it.action)
      ACT_ADD: begin
        if (row_is_live[it.row]) begin
          r.status = ST_LIVE;
        end else begin
          store = it.column >= min_col;
          if (store && row_len[it.row] >= ROW_CAP) begin
            r.status = ST_FULL;
          end else begin
            if (col_wt[it.column] == 0) begin
              col_wt[it.column] = 8'd1;
              n_live_cols++;
            end else if (col_wt[it.column] != WSAT) begin
              col_wt[it.column]++;
            end
            r.col_weight = col_wt[it.column];
            if (store) begin
              row_cols[it.row][row_len[it.row]] = it.column;
              row_len[it.row]++;
            end
          end
          if (it.last) begin
            row_is_live[it.row] = 1'b1;
            n_live_rows++;
          end
        end
      end
      ACT_DEL: begin
        if (!row_is_live[it.row]) begin
          r.status = ST_NOT_LIVE;
        end else begin
          for (int k = 0; k < row_len[it.row]; k++) begin
            c = row_cols[it.row][k];
            if (col_wt[c] != 0 && col_wt[c] != WSAT) begin
              col_wt[c]--;
              if (col_wt[c] == 0) n_live_cols--;
            end
          end
          row_is_live[it.row] = 1'b0;
          row_len[it.row] = 0;
          n_live_rows--;
        end
      end
      ACT_SUM2: begin
        for (int i = 0; i < NCOLS; i++) col_pair[i] = '0;
        for (int rw = 0; rw < NROWS; rw++) begin
          if (row_is_live[rw]) begin
            for (int k = 0; k < row_len[rw]; k++) begin
              c = row_cols[rw][k];
              if (col_wt[c] == 8'd2) col_pair[c] = col_pair[c] + PAIR_W'(rw);
            end
          end
        end
      end
      default: begin
        r.col_weight = col_wt[it.column];
        r.pair_row_sum = col_pair[it.column];
      end
    endcase
    r.live_rows = n_live_rows;
    r.live_cols = n_live_cols;
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, int rw, int col, bit lst);
    item_t it;
    it.action = act;
    it.row = 10'(rw);
    it.column = 12'(col);
    it.last = lst;
    while (!calm && $urandom_range(99) < 29) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_results.push_back(purge_table_step(it));
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_min_column(int v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= MINC_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    min_col = MINC_W'(v);
  endtask

  task automatic test_basic_actions();
    send_item(ACT_ADD, 0, 5, 0);
    send_item(ACT_ADD, 0, 7, 1);
    send_item(ACT_ADD, 1, 5, 0);
    send_item(ACT_ADD, 1, 4095, 1);
    send_item(ACT_QUERY, 0, 5, 0);
    send_item(ACT_SUM2, 0, 0, 0);
    send_item(ACT_QUERY, 0, 5, 1);
    send_item(ACT_QUERY, 1023, 0, 0);
    send_item(ACT_ADD, 0, 9, 1);
    send_item(ACT_DEL, 2, 0, 0);
    send_item(ACT_ADD, 3, 9, 0);
    send_item(ACT_DEL, 3, 0, 0);
    send_item(ACT_ADD, 3, 9, 1);
    send_item(ACT_DEL, 0, 0, 0);
    send_item(ACT_QUERY, 0, 7, 0);
    send_item(ACT_ADD, 1023, 0, 1);
    send_item(ACT_QUERY, 0, 4095, 0);
    send_item(ACT_DEL, 1023, 4095, 1);
    send_item(ACT_DEL, 1, 0, 0);
    send_item(ACT_DEL, 3, 0, 0);
  endtask

  task automatic test_row_full();
    for (int k = 0; k <= ROW_CAP + 1; k++) send_item(ACT_ADD, 10, 200 + k, k == ROW_CAP + 1);
    send_item(ACT_DEL, 10, 0, 0);
  endtask

  task automatic test_weight_saturation();
    for (int rw = 0; rw < 260; rw++) send_item(ACT_ADD, 400 + rw, 100, 1);
    send_item(ACT_QUERY, 0, 100, 0);
    for (int rw = 0; rw < 260; rw++) send_item(ACT_DEL, 400 + rw, 0, 0);
    send_item(ACT_QUERY, 0, 100, 0);
  endtask

  task automatic test_random_rows(int n_items);
    int sent;
    int rw;
    int len;
    int col;
    sent = 0;
    while (sent < n_items) begin
      calm = (sent > n_items / 4) && (sent < n_items / 2);
      rw = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(127);
      case ($urandom_range(19))
        0: send_item(ACT_SUM2, $urandom_range(1023), $urandom_range(4095), $urandom_range(1));
        1, 2: send_item(2'($urandom_range(3) == 2 ? 3 : $urandom_range(3)), $urandom_range(1023),
                        $urandom_range(4095), $urandom_range(1));
        3, 4, 5: send_item(ACT_QUERY, rw, $urandom_range(63), $urandom_range(1));
        default: begin
          if (row_is_live[rw] && $urandom_range(4) != 0) begin
            send_item(ACT_DEL, rw, $urandom_range(4095), $urandom_range(1));
          end else begin
            len = ($urandom_range(15) == 0) ? $urandom_range(40, 33) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
              col = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(63);
              send_item(ACT_ADD, rw, col, k == len - 1);
            end
            sent += len - 1;
          end
        end
      endcase
      sent++;
    end
    calm = 1'b0;
  endtask

  // result side: random stall, compare each beat with the oldest expectation
  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    result_ready <= calm || ($urandom_range(99) >= 29);
    if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, result);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, result.status);
        check_field("col_weight", exp_r.col_weight, result.col_weight);
        check_field("pair_row_sum", exp_r.pair_row_sum, result.pair_row_sum);
        check_field("live_rows", exp_r.live_rows, result.live_rows);
        check_field("live_cols", exp_r.live_cols, result.live_cols);
      end
    end
  end

  initial begin
    for (int i = 0; i < NCOLS; i++) begin
      col_wt[i] = '0;
      col_pair[i] = '0;
    end
    for (int i = 0; i < NROWS; i++) begin
      row_len[i] = 0;
      row_is_live[i] = 1'b0;
    end
    n_live_rows = '0;
    n_live_cols = '0;
    min_col = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_actions();
    test_row_full();
    test_weight_saturation();
    test_random_rows(250);
    set_min_column(4096);
    test_random_rows(250);
    set_min_column(40);
    test_random_rows(250);
    set_min_column($urandom_range(4096));
    test_random_rows(250);
    set_min_column(0);
    test_random_rows(200);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/smpt_pkg.sv
hdl/smpt_ram.sv
hdl/smpt_ctrl.sv
hdl/smpt_dp.sv
hdl/sparse_matrix_purge_table_unit.sv
tb/sv/tb.sv
